### hdl/srtf_pkg.sv
// Shared types and constants for the shortest-remaining-time scheduler.
`timescale 1ns / 1ps

package srtf_pkg;

	// Fixed field widths of the request and result ports.
	localparam int DATA_W = 16;
	localparam int SLOT_W = 4;

	// Request codes.
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_TICK  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// One job table entry as read out of the table memories.
	typedef struct packed {
		logic [DATA_W-1:0] arr;
		logic [DATA_W-1:0] burst;
		logic [DATA_W-1:0] rem;
	} entry_t;

	// Control from the sequencer to the compare unit.
	typedef struct packed {
		logic init;
		logic take;
	} pick_ctl_t;

endpackage

### hdl/srtf_table.sv
// Job table: arrival, burst and remaining-time memories plus per-slot valid bits.
`timescale 1ns / 1ps

module srtf_table #(
	parameter int NUM_SLOTS = 16,
	parameter int IDX_W     = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clr,
	input  logic                  ld_en,
	input  logic [IDX_W-1:0]      ld_addr,
	input  logic [srtf_pkg::DATA_W-1:0] ld_arr,
	input  logic [srtf_pkg::DATA_W-1:0] ld_burst,
	input  logic                  up_en,
	input  logic [IDX_W-1:0]      up_addr,
	input  logic [srtf_pkg::DATA_W-1:0] up_rem,
	input  logic [IDX_W-1:0]      rd_addr,
	output srtf_pkg::entry_t      rd_entry,
	output logic                  rd_valid
);
	import srtf_pkg::*;

	logic [DATA_W-1:0]    arr_mem [NUM_SLOTS];
	logic [DATA_W-1:0]    bur_mem [NUM_SLOTS];
	logic [DATA_W-1:0]    rem_mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] valid_q;
	entry_t               rd_entry_q;
	logic                 rd_valid_q;

	// Load writes a whole entry; a tick update rewrites only the remaining time.
	always_ff @(posedge clk) begin
		if (ld_en) begin
			arr_mem[ld_addr] <= ld_arr;
			bur_mem[ld_addr] <= ld_burst;
		end
		if (ld_en) begin
			rem_mem[ld_addr] <= ld_burst;
		end else if (up_en) begin
			rem_mem[up_addr] <= up_rem;
		end
	end

	// Registered read of the entry being scanned.
	always_ff @(posedge clk) begin
		rd_entry_q.arr   <= arr_mem[rd_addr];
		rd_entry_q.burst <= bur_mem[rd_addr];
		rd_entry_q.rem   <= rem_mem[rd_addr];
	end

	// Valid bits: set by a load, all dropped by a clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (ld_en) begin
				valid_q[ld_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_entry = rd_entry_q;
	assign rd_valid = rd_valid_q;

endmodule

### hdl/srtf_pick.sv
// Shared compare unit that keeps the best eligible job seen during a scan.
`timescale 1ns / 1ps

module srtf_pick #(
	parameter int IDX_W     = 4,
	parameter int TIME_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  srtf_pkg::pick_ctl_t   ctl,
	input  srtf_pkg::entry_t      cand,
	input  logic                  cand_valid,
	input  logic [IDX_W-1:0]      cand_idx,
	input  logic [TIME_BITS-1:0]  now,
	output logic                  found,
	output logic [IDX_W-1:0]      best_idx,
	output srtf_pkg::entry_t      best
);
	import srtf_pkg::*;

	localparam int CW = (TIME_BITS > DATA_W) ? TIME_BITS : DATA_W;

	logic         found_q;
	logic [IDX_W-1:0] best_idx_q;
	entry_t       best_q;
	logic         elig;
	logic         better;

	// Eligible: loaded, not finished, and already arrived.
	assign elig = cand_valid && (cand.rem != '0) && (CW'(cand.arr) <= CW'(now));

	// Strictly better only, so an exact tie keeps the lower slot seen first.
	assign better = !found_q || (cand.rem < best_q.rem) ||
		((cand.rem == best_q.rem) && (cand.arr < best_q.arr));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.init) begin
			found_q <= 1'b0;
		end else if (ctl.take && elig) begin
			found_q <= 1'b1;
		end
	end

	// Best-candidate payload follows the same win condition.
	always_ff @(posedge clk) begin
		if (!ctl.init && ctl.take && elig && better) begin
			best_q     <= cand;
			best_idx_q <= cand_idx;
		end
	end

	assign found    = found_q;
	assign best_idx = best_idx_q;
	assign best     = best_q;

endmodule

### hdl/shortest_remaining_time_scheduler.sv
// Top level: request sequencer, time counter and result register.
//
// Channel   Direction  Handshake               Fields
// request   in         start high, busy low    req_type, slot, arrival, burst
// result    out        done, one cycle         idle, chosen_slot, chosen_burst,
//                                              left_after, elapsed
//
// Load and clear take effect at the transfer edge; busy stays low.
// A tick scans the table one slot per cycle through one compare unit,
// then passes through a drain state and an update state before the done strobe,
// and a new request is taken in the cycle that done is shown.
// Reset empties the table and zeroes the time counter at once.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module shortest_remaining_time_scheduler #(
	parameter int NUM_SLOTS = 16,
	parameter int TIME_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    req_type,
	input  logic [srtf_pkg::SLOT_W-1:0]   slot,
	input  logic [srtf_pkg::DATA_W-1:0]   arrival,
	input  logic [srtf_pkg::DATA_W-1:0]   burst,
	output logic                          done,
	output logic                          idle,
	output logic [srtf_pkg::SLOT_W-1:0]   chosen_slot,
	output logic [srtf_pkg::DATA_W-1:0]   chosen_burst,
	output logic [srtf_pkg::DATA_W-1:0]   left_after,
	output logic [srtf_pkg::DATA_W-1:0]   elapsed
);
	import srtf_pkg::*;

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW    = (TIME_BITS > DATA_W) ? TIME_BITS : DATA_W;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_UPDATE = 2'd3;

	logic [1:0]           state_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     idx_s1;
	logic                 take_s1;
	logic [TIME_BITS-1:0] time_q;
	logic [TIME_BITS-1:0] time_nxt;
	logic [CW-1:0]        time_wide;

	logic                 done_q;
	logic                 idle_q;
	logic [SLOT_W-1:0]    chosen_slot_q;
	logic [DATA_W-1:0]    chosen_burst_q;
	logic [DATA_W-1:0]    left_after_q;
	logic [DATA_W-1:0]    elapsed_q;

	logic                 accept;
	logic                 slot_ok;
	logic                 ld_en;
	logic                 clr;
	logic                 tick_go;
	logic                 up_en;
	logic [DATA_W-1:0]    left_nxt;
	entry_t               rd_entry;
	logic                 rd_valid;
	pick_ctl_t            pick_ctl;
	logic                 best_found;
	logic [IDX_W-1:0]     best_idx;
	entry_t               best;

	// Request decode at the transfer edge.
	assign accept  = start && !busy;
	assign slot_ok = (32'(slot) < NUM_SLOTS);
	assign ld_en   = accept && (req_type == REQ_LOAD) && slot_ok;
	assign clr     = accept && (req_type == REQ_CLEAR);
	assign tick_go = accept && (req_type == REQ_TICK);
	assign up_en   = (state_q == ST_UPDATE) && best_found;
	assign left_nxt = best.rem - DATA_W'(1);

	assign pick_ctl.init = tick_go;
	assign pick_ctl.take = take_s1;

	// Saturating time step and its clamp to the result field.
	assign time_nxt  = (time_q == '1) ? time_q : time_q + TIME_BITS'(1);
	assign time_wide = CW'(time_nxt);

	srtf_table #(
		.NUM_SLOTS(NUM_SLOTS),
		.IDX_W    (IDX_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (clr),
		.ld_en   (ld_en),
		.ld_addr (IDX_W'(slot)),
		.ld_arr  (arrival),
		.ld_burst(burst),
		.up_en   (up_en),
		.up_addr (best_idx),
		.up_rem  (left_nxt),
		.rd_addr (idx_q),
		.rd_entry(rd_entry),
		.rd_valid(rd_valid)
	);

	srtf_pick #(
		.IDX_W    (IDX_W),
		.TIME_BITS(TIME_BITS)
	) u_pick (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (pick_ctl),
		.cand      (rd_entry),
		.cand_valid(rd_valid),
		.cand_idx  (idx_s1),
		.now       (time_q),
		.found     (best_found),
		.best_idx  (best_idx),
		.best      (best)
	);

	// Sequencer: scan every slot, let the last read land, then update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			take_s1 <= 1'b0;
			time_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			take_s1 <= (state_q == ST_SCAN);
			done_q  <= (state_q == ST_UPDATE);
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (clr) begin
						time_q <= '0;
					end
					if (tick_go) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + IDX_W'(1);
					if (idx_q == IDX_W'(NUM_SLOTS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					time_q  <= time_nxt;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Slot index travels alongside the registered table read.
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
	end

	// Result register, loaded in the update cycle.
	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE) begin
			idle_q <= !best_found;
			if (best_found) begin
				chosen_slot_q  <= SLOT_W'(best_idx);
				chosen_burst_q <= best.burst;
				left_after_q   <= left_nxt;
			end else begin
				chosen_slot_q  <= '0;
				chosen_burst_q <= '0;
				left_after_q   <= '0;
			end
			elapsed_q <= (time_wide > CW'({DATA_W{1'b1}})) ? {DATA_W{1'b1}}
				: time_wide[DATA_W-1:0];
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign idle         = idle_q;
	assign chosen_slot  = chosen_slot_q;
	assign chosen_burst = chosen_burst_q;
	assign left_after   = left_after_q;
	assign elapsed      = elapsed_q;

`ifndef SYNTHESIS
	// A result strobe only follows the update cycle.
	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_UPDATE))
		else $error("result strobe without an update cycle");

	// An idle tick reports all-zero job fields.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && idle) |-> (chosen_slot == '0 && chosen_burst == '0 && left_after == '0))
		else $error("idle result carries job fields");

	// A chosen job always had time left before this tick.
	a_found_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		up_en |-> (best.rem != '0))
		else $error("chosen job had no remaining time");

	// A tick transfer starts the scan on the next cycle.
	a_tick_scans: assert property (@(posedge clk) disable iff (!arst_n)
		tick_go |=> (state_q == ST_SCAN && idx_q == '0))
		else $error("tick did not start a scan");

	// Load and clear never make the block busy.
	a_load_clear_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(ld_en || clr) |=> !busy)
		else $error("load or clear left the block busy");
`endif

endmodule
